### design/ham_pkg.sv
// Shared constants, status codes and elaboration-time helpers for the Hamming codec.
// No dependencies.
package ham_pkg;

  localparam int CODE_BITS     = 64;  // width of the codeword and data ports
  localparam int WIDTH_BITS    = 6;   // width of the data width register
  localparam int SYN_BITS      = 6;   // check bits needed by the longest codeword
  localparam int MAX_DATA_BITS = 57;  // data positions in a 64-position codeword
  localparam int EPOS_BITS     = 7;
  localparam int CHECK_SLOTS   = 7;   // power-of-two positions up to 64

  // Operation carried by the kind field of an input item.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CORRECTED = 2'd1,
    STATUS_OUTSIDE   = 2'd2
  } status_t;

  // Code length n = k + r for a data width setting. A width of zero acts as one,
  // and widths whose codeword would not fit in CODE_BITS saturate.
  function automatic logic [WIDTH_BITS-1:0] code_len_for(logic [WIDTH_BITS-1:0] width);
    int k;
    int n;
    k = (width == '0) ? 1 : int'(width);
    if (k > MAX_DATA_BITS) k = MAX_DATA_BITS;
    n = 0;
    // Walk down so that the last hit is the smallest check count.
    for (int r = CHECK_SLOTS; r >= 0; r--) begin
      if ((1 << r) >= k + r + 1) n = k + r;
    end
    return WIDTH_BITS'(n);
  endfunction

  localparam logic [WIDTH_BITS-1:0] RESET_CODE_LEN = code_len_for(WIDTH_BITS'(4));

  // Codeword bit index (position minus one) that carries data bit d.
  function automatic int data_index(int d);
    int cnt;
    int idx;
    cnt = 0;
    idx = 0;
    for (int pos = 1; pos <= CODE_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (cnt == d) idx = pos - 1;
        cnt++;
      end
    end
    return idx;
  endfunction

  // Codeword bits covered by check j: positions whose index has bit j set.
  function automatic logic [CODE_BITS-1:0] group_mask(int j);
    logic [CODE_BITS-1:0] m;
    for (int i = 0; i < CODE_BITS; i++) begin
      m[i] = (((i + 1) >> j) & 1) != 0;
    end
    return m;
  endfunction

endpackage

### design/hamming_codec.sv
// Single-error-correcting Hamming encoder and decoder, top level.
// Depends on ham_pkg for constants, status codes and the position tables.

// The codec takes one item per cycle while the output is not stalled. An item
// passes through an input register, one level of XOR trees with the data scatter or
// gather, and an output register. A stalled output holds its
// result while one more item waits in the input register. The data width register
// (write cfg_we with cfg_data, reset 4) sets k; the check count r is the smallest
// with 2^r >= k + r + 1, a width of 0 acts as 1 and widths above 57 act as 57.
// Check bits sit at positions 1, 2, 4, ... with codeword bit 0 as position 1.
// On decode a nonzero syndrome within the code length flips that bit (status 1);
// a syndrome beyond it leaves the word as is (status 2). Write the width only
// while no item is in flight.
module hamming_codec
  import ham_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [WIDTH_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [CODE_BITS-1:0]  data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CODE_BITS-1:0]  data_out,
  output logic [1:0]            status,
  output logic [EPOS_BITS-1:0]  error_position
);

  logic [WIDTH_BITS-1:0] code_len;
  logic                  s1_valid;
  logic                  s1_kind;
  logic [CODE_BITS-1:0]  s1_word;
  logic                  advance;

  logic [CODE_BITS-1:0]     len_mask;
  logic [CODE_BITS-1:0]     placed;
  logic [CODE_BITS-1:0]     masked;
  logic [CODE_BITS-1:0]     check_bits;
  logic [CODE_BITS-1:0]     flip;
  logic [CODE_BITS-1:0]     fixed_word;
  logic [MAX_DATA_BITS-1:0] gathered;
  logic [SYN_BITS-1:0]      syn;
  logic                     syn_inside;

  logic [CODE_BITS-1:0] data_out_next;
  status_t              status_next;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_len  <= RESET_CODE_LEN;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) code_len <= code_len_for(cfg_data);
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind <= kind;
      s1_word <= data_in;
    end
    if (advance && s1_valid) begin
      data_out       <= data_out_next;
      status         <= status_next;
      error_position <= s1_kind ? EPOS_BITS'(syn) : '0;
    end
  end

  // Fixed wiring between data bit order and codeword positions.
  for (genvar d = 0; d < MAX_DATA_BITS; d++) begin : g_map
    localparam int Idx = data_index(d);
    assign placed[Idx] = s1_word[d];
    assign gathered[d] = fixed_word[Idx];
  end

  for (genvar j = 0; j < CHECK_SLOTS; j++) begin : g_slot
    assign placed[(1 << j) - 1] = 1'b0;
  end

  for (genvar i = 0; i < CODE_BITS; i++) begin : g_len
    assign len_mask[i] = (EPOS_BITS'(i) < EPOS_BITS'(code_len));
  end

  // Encode checks the scattered data, decode checks the received word. Checks
  // above the code length cover no live position and come out zero.
  assign masked = (s1_kind ? s1_word : placed) & len_mask;

  for (genvar j = 0; j < SYN_BITS; j++) begin : g_par
    localparam logic [CODE_BITS-1:0] Group = group_mask(j);
    assign syn[j] = ^(masked & Group);
  end

  always_comb begin
    check_bits = '0;
    for (int j = 0; j < SYN_BITS; j++) begin
      check_bits[(1 << j) - 1] = syn[j];
    end
  end

  assign syn_inside = (syn != '0) && (syn <= code_len);
  assign flip       = syn_inside ? (CODE_BITS'(1) << (syn - SYN_BITS'(1))) : '0;
  assign fixed_word = masked ^ flip;

  always_comb begin
    if (s1_kind) begin
      data_out_next = CODE_BITS'(gathered);
      if (syn == '0) begin
        status_next = STATUS_OK;
      end else if (syn_inside) begin
        status_next = STATUS_CORRECTED;
      end else begin
        status_next = STATUS_OUTSIDE;
      end
    end else begin
      data_out_next = masked | check_bits;
      status_next   = STATUS_OK;
    end
  end

  // A zero status always comes with no reported position.
  a_ok_no_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OK |-> error_position == '0)
    else $error("clean result reports an error position");

  a_corr_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_CORRECTED |->
      error_position != '0 && error_position <= EPOS_BITS'(code_len))
    else $error("corrected position outside the codeword");

  a_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_OUTSIDE |-> error_position > EPOS_BITS'(code_len))
    else $error("out-of-range status with an in-range syndrome");

  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled while the pipeline can move");

endmodule
